// ----- design/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_STAGES   = 32;
  localparam int OPW           = 36;   // atan2 operand width
  localparam int XW            = 45;   // CORDIC x/y width
  localparam int ZW            = 28;   // angle width, radians with 24 fraction bits
  localparam int VW            = 64;   // square root datapath width
  localparam int NORM_TOP      = 40;   // normalised magnitude sits in [2^40, 2^41)
  localparam int LAT           = 2 + 2 + SQRT_STAGES + 2 + CORDIC_STAGES + 3;

  localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [23:0]   DEG_K       = 24'sd3754936;

  localparam logic [23:0] ATAN_TAB [24] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123,   24'd131069,  24'd65536,   24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,     24'd256,     24'd128,
    24'd64,       24'd32,      24'd16,      24'd8,       24'd4,       24'd2
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic                 off_pos;
    logic                 off_neg;
  } vec_t;

  typedef struct packed {
    logic [VW-1:0] v;
    logic [VW-1:0] r;
  } sqrt_t;

  // Add the half-turn offset, clamp to [-pi, pi], zero vector gives zero.
  function automatic logic signed [ZW-1:0] vec_angle(vec_t s);
    logic signed [ZW-1:0] t;
    t = s.z;
    if (s.off_pos) begin
      t = t + ANG_PI;
    end else if (s.off_neg) begin
      t = t - ANG_PI;
    end
    if (t > ANG_PI) t = ANG_PI;
    if (t < -ANG_PI) t = -ANG_PI;
    if (s.zero) t = '0;
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- design/qte_sqrt_cell.sv -----
`default_nettype none
module qte_sqrt_cell (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [qte_pkg::VW-1:0] bit_i,
  input  wire qte_pkg::sqrt_t        sq_i,
  output qte_pkg::sqrt_t             sq_o
);
  import qte_pkg::*;

  sqrt_t sq_d, sq_q;
  logic [VW-1:0] trial;

  always_comb begin
    trial = sq_i.r + bit_i;
    if (sq_i.v >= trial) begin
      sq_d.v = sq_i.v - trial;
      sq_d.r = (sq_i.r >> 1) + bit_i;
    end else begin
      sq_d.v = sq_i.v;
      sq_d.r = sq_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sq_q <= sq_d;
  end

  assign sq_o = sq_q;
endmodule
`default_nettype wire

// ----- design/qte_cordic_cell.sv -----
`default_nettype none
module qte_cordic_cell (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [4:0]                   sh_i,
  input  wire logic signed [qte_pkg::ZW-1:0] ang_i,
  input  wire qte_pkg::vec_t                vec_i,
  output qte_pkg::vec_t                     vec_o
);
  import qte_pkg::*;

  vec_t vec_d, vec_q;
  logic signed [XW-1:0] x, y, dx, dy;

  always_comb begin
    x  = vec_i.x;
    y  = vec_i.y;
    dx = y >>> sh_i;
    dy = x >>> sh_i;
    vec_d = vec_i;
    if (!y[XW-1]) begin
      vec_d.x = x + dx;
      vec_d.y = y - dy;
      vec_d.z = vec_i.z + ang_i;
    end else begin
      vec_d.x = x - dx;
      vec_d.y = y + dy;
      vec_d.z = vec_i.z - ang_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;
endmodule
`default_nettype wire

// ----- design/qte_vec_prep.sv -----
`default_nettype none
module qte_vec_prep (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [qte_pkg::OPW-1:0] y_i,
  input  wire logic signed [qte_pkg::OPW-1:0] x_i,
  output qte_pkg::vec_t                      vec_o
);
  import qte_pkg::*;

  logic signed [OPW-1:0] xa, ya, ay;
  logic [OPW-1:0]        m;
  logic                  neg;

  logic signed [OPW-1:0] x1_q, y1_q;
  logic [OPW-1:0]        m1_q;
  logic                  zero1_q, offp1_q, offn1_q;

  logic signed [XW-1:0] xs, ys;
  logic [XW-1:0]        ms;
  vec_t                 vec_d, vec_q;

  // Fold the left half-plane onto the right and take the larger magnitude.
  always_comb begin
    neg = x_i[OPW-1];
    xa  = neg ? -x_i : x_i;
    ya  = neg ? -y_i : y_i;
    ay  = ya[OPW-1] ? -ya : ya;
    m   = (ay > xa) ? ay : xa;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= xa;
      y1_q    <= ya;
      m1_q    <= m;
      zero1_q <= (x_i == '0) && (y_i == '0);
      offp1_q <= neg && !y_i[OPW-1];
      offn1_q <= neg && y_i[OPW-1];
    end
  end

  // Normalise so the larger magnitude lands in [2^40, 2^41).
  always_comb begin
    xs = XW'(x1_q);
    ys = XW'(y1_q);
    ms = XW'(m1_q);
    for (int k = 5; k >= 0; k--) begin
      if (ms < (XW'(1) << (NORM_TOP + 1 - (1 << k)))) begin
        ms = ms << (1 << k);
        xs = xs <<< (1 << k);
        ys = ys <<< (1 << k);
      end
    end
    vec_d.x       = xs;
    vec_d.y       = ys;
    vec_d.z       = '0;
    vec_d.zero    = zero1_q;
    vec_d.off_pos = offp1_q;
    vec_d.off_neg = offn1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) vec_q <= vec_d;
  end

  assign vec_o = vec_q;
endmodule
`default_nettype wire

// ----- design/quaternion_to_euler_angles_top.sv -----
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Latency is set by the 32-cell square root chain and the 16-cell CORDIC chains.
// Reset clears the valid pipeline and selects radian output.
`default_nettype none
module quaternion_to_euler_angles_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] real_part_i,
  input  wire logic signed [15:0] i_part_i,
  input  wire logic signed [15:0] j_part_i,
  input  wire logic signed [15:0] k_part_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      yaw_angle_o,
  output logic signed [15:0]      pitch_angle_o,
  output logic signed [15:0]      roll_angle_o,
  output logic                    degenerate_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i
);
  import qte_pkg::*;

  typedef struct packed {
    logic signed [OPW-1:0] yy;
    logic signed [OPW-1:0] yx;
    logic signed [OPW-1:0] ry;
    logic signed [OPW-1:0] rx;
    logic signed [OPW-1:0] a;
    logic                  degen;
    logic                  pos;
    logic                  neg;
  } side_t;

  typedef struct packed {
    logic degen;
    logic pos;
    logic neg;
  } pflag_t;

  localparam int PF_LEN = 2 + CORDIC_STAGES;

  logic           adv;
  logic [LAT-1:0] vld_q;
  logic           deg_mode_q;

  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      deg_mode_q <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[LAT-2:0], in_valid_i};
      if (cfg_valid_i) deg_mode_q <= cfg_data_i;
    end
  end

  // Products
  logic signed [31:0] p_rr_q, p_ii_q, p_jj_q, p_kk_q, p_ij_q;
  logic signed [31:0] p_kr_q, p_jk_q, p_ir_q, p_jr_q, p_ik_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_rr_q <= real_part_i * real_part_i;
      p_ii_q <= i_part_i * i_part_i;
      p_jj_q <= j_part_i * j_part_i;
      p_kk_q <= k_part_i * k_part_i;
      p_ij_q <= i_part_i * j_part_i;
      p_kr_q <= k_part_i * real_part_i;
      p_jk_q <= j_part_i * k_part_i;
      p_ir_q <= i_part_i * real_part_i;
      p_jr_q <= j_part_i * real_part_i;
      p_ik_q <= i_part_i * k_part_i;
    end
  end

  // Product sums
  logic signed [OPW-1:0] yy2_q, yx2_q, ry2_q, rx2_q, a2_q, n2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yy2_q <= (OPW'(p_ij_q) + OPW'(p_kr_q)) <<< 1;
      yx2_q <= OPW'(p_ii_q) - OPW'(p_jj_q) - OPW'(p_kk_q) + OPW'(p_rr_q);
      ry2_q <= (OPW'(p_jk_q) + OPW'(p_ir_q)) <<< 1;
      rx2_q <= OPW'(p_kk_q) + OPW'(p_rr_q) - OPW'(p_ii_q) - OPW'(p_jj_q);
      a2_q  <= (OPW'(p_jr_q) - OPW'(p_ik_q)) <<< 1;
      n2_q  <= OPW'(p_ii_q) + OPW'(p_jj_q) + OPW'(p_kk_q) + OPW'(p_rr_q);
    end
  end

  // Pitch argument: scale the norm below 2^31, clamp test, form n-a and n+a
  logic [1:0]            nsh;
  logic signed [OPW-1:0] ns, as_v, u1, u2;
  side_t                 side3_d, side3_q, side4_q;
  logic [31:0]           u1_q, u2_q;
  logic [VW-1:0]         prod_q;

  always_comb begin
    if (n2_q[32]) begin
      nsh = 2'd2;
    end else if (n2_q[31]) begin
      nsh = 2'd1;
    end else begin
      nsh = 2'd0;
    end
    ns   = n2_q >>> nsh;
    as_v = a2_q >>> nsh;
    u1   = ns - as_v;
    u2   = ns + as_v;
    side3_d.yy    = yy2_q;
    side3_d.yx    = yx2_q;
    side3_d.ry    = ry2_q;
    side3_d.rx    = rx2_q;
    side3_d.a     = as_v;
    side3_d.degen = (n2_q == '0);
    side3_d.pos   = (as_v >= ns);
    side3_d.neg   = (as_v <= -ns);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q <= side3_d;
      u1_q    <= (side3_d.pos || side3_d.neg) ? '0 : u1[31:0];
      u2_q    <= (side3_d.pos || side3_d.neg) ? '0 : u2[31:0];
      side4_q <= side3_q;
      prod_q  <= u1_q * u2_q;
    end
  end

  // Integer square root, one result bit per cell
  sqrt_t sq [SQRT_STAGES+1];
  side_t sd_q [SQRT_STAGES];

  assign sq[0].v = prod_q;
  assign sq[0].r = '0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    localparam logic [VW-1:0] SqBit = VW'(1) << (2 * (SQRT_STAGES - 1 - k));
    qte_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .bit_i (SqBit),
      .sq_i  (sq[k]),
      .sq_o  (sq[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side4_q;
      for (int k = 1; k < SQRT_STAGES; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  side_t                 sde;
  logic signed [OPW-1:0] op_y [3];
  logic signed [OPW-1:0] op_x [3];

  assign sde     = sd_q[SQRT_STAGES-1];
  assign op_y[0] = sde.yy;
  assign op_x[0] = sde.yx;
  assign op_y[1] = sde.a;
  assign op_x[1] = OPW'(sq[SQRT_STAGES].r[30:0]);
  assign op_y[2] = sde.ry;
  assign op_x[2] = sde.rx;

  pflag_t pf_q [PF_LEN];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pf_q[0] <= '{degen: sde.degen, pos: sde.pos, neg: sde.neg};
      for (int k = 1; k < PF_LEN; k++) pf_q[k] <= pf_q[k-1];
    end
  end

  // Three vectoring CORDIC chains: yaw, pitch, roll
  vec_t cv [3][CORDIC_STAGES+1];

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    qte_vec_prep u_prep (
      .clk_i (clk_i),
      .en_i  (adv),
      .y_i   (op_y[ch]),
      .x_i   (op_x[ch]),
      .vec_o (cv[ch][0])
    );
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      qte_cordic_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .sh_i  (5'(k)),
        .ang_i (ZW'(ATAN_TAB[k])),
        .vec_i (cv[ch][k]),
        .vec_o (cv[ch][k+1])
      );
    end
  end

  // Final angle, unit conversion
  logic signed [ZW-1:0] zf_q [3];
  logic signed [ZW-1:0] zm_q [3];
  logic signed [51:0]   mp_q [3];
  logic                 dg55_q, dg56_q;
  pflag_t               pfe;

  assign pfe = pf_q[PF_LEN-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zf_q[0] <= vec_angle(cv[0][CORDIC_STAGES]);
      zf_q[2] <= vec_angle(cv[2][CORDIC_STAGES]);
      if (pfe.degen) begin
        zf_q[1] <= '0;
      end else if (pfe.pos) begin
        zf_q[1] <= ANG_HALF_PI;
      end else if (pfe.neg) begin
        zf_q[1] <= -ANG_HALF_PI;
      end else begin
        zf_q[1] <= vec_angle(cv[1][CORDIC_STAGES]);
      end
      dg55_q <= pfe.degen;
      for (int c = 0; c < 3; c++) begin
        mp_q[c] <= zf_q[c] * DEG_K;
        zm_q[c] <= zf_q[c];
      end
      dg56_q <= dg55_q;
    end
  end

  logic signed [15:0]   ang_d [3];
  logic signed [51:0]   dsum [3];
  logic signed [ZW-1:0] rsum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dsum[c] = (mp_q[c] + 52'sd4294967296) >>> 33;
      rsum[c] = (zm_q[c] + ZW'(1024)) >>> 11;
      ang_d[c] = deg_mode_q ? dsum[c][15:0] : rsum[c][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      yaw_angle_o   <= ang_d[0];
      pitch_angle_o <= ang_d[1];
      roll_angle_o  <= ang_d[2];
      degenerate_o  <= dg56_q;
    end
  end

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      (yaw_angle_o == 16'sd0 && pitch_angle_o == 16'sd0 && roll_angle_o == 16'sd0))
    else $error("degenerate result with nonzero angle");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= 16'sd12868 && pitch_angle_o >= -16'sd12868))
    else $error("pitch beyond a quarter turn");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at pipeline entry");
`endif

endmodule
`default_nettype wire
